FILE: rtl/core/script_scratch_memory_alu_macros.svh
// Assertion macros shared by the script scratch memory ALU.
`ifndef SCRIPT_SCRATCH_MEMORY_ALU_MACROS_SVH
`define SCRIPT_SCRATCH_MEMORY_ALU_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSMALU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSMALU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ssmalu_pkg.sv
`timescale 1ns / 1ps

package ssmalu_pkg;

    localparam int DATA_W    = 8;
    localparam int ADDR_W    = 8;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    // Operation codes.
    localparam logic [7:0] ACT_STORE_IMM = 8'd0;
    localparam logic [7:0] ACT_ADD_IMM   = 8'd1;
    localparam logic [7:0] ACT_SUB_IMM   = 8'd2;
    localparam logic [7:0] ACT_STORE_IND = 8'd3;
    localparam logic [7:0] ACT_ADD_IND   = 8'd4;
    localparam logic [7:0] ACT_SUB_IND   = 8'd5;
    localparam logic [7:0] ACT_EQ_IMM    = 8'd6;
    localparam logic [7:0] ACT_NE_IMM    = 8'd7;
    localparam logic [7:0] ACT_GT_IMM    = 8'd8;
    localparam logic [7:0] ACT_GE_IMM    = 8'd9;
    localparam logic [7:0] ACT_LE_IMM    = 8'd10;
    localparam logic [7:0] ACT_LT_IMM    = 8'd11;
    localparam logic [7:0] ACT_EQ_IND    = 8'd12;
    localparam logic [7:0] ACT_NE_IND    = 8'd13;
    localparam logic [7:0] ACT_GT_IND    = 8'd14;
    localparam logic [7:0] ACT_GE_IND    = 8'd15;
    localparam logic [7:0] ACT_LE_IND    = 8'd16;
    localparam logic [7:0] ACT_LT_IND    = 8'd17;

    // Control flow outcome of one command.
    typedef enum logic [1:0] {
        FLOW_NONE = 2'd0,
        FLOW_JUMP = 2'd1,
        FLOW_SKIP = 2'd2
    } flow_t;

    // Result of executing one command.
    typedef struct packed {
        flow_t             flow;
        logic [DATA_W-1:0] value;
        logic              write;
    } exec_res_t;

endpackage

FILE: rtl/core/ssmalu_mem.sv
`timescale 1ns / 1ps

module ssmalu_mem (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [ssmalu_pkg::ADDR_W-1:0] rd_addr_a,
    input  logic [ssmalu_pkg::ADDR_W-1:0] rd_addr_b,
    input  logic                         wr_en,
    input  logic [ssmalu_pkg::ADDR_W-1:0] wr_addr,
    input  logic [ssmalu_pkg::DATA_W-1:0] wr_data,
    output logic [ssmalu_pkg::DATA_W-1:0] rd_data_a,
    output logic [ssmalu_pkg::DATA_W-1:0] rd_data_b
);
    import ssmalu_pkg::*;

    logic [DATA_W-1:0]    mem_reg [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] valid_reg;
    logic [DATA_W-1:0]    rd_a_reg;
    logic [DATA_W-1:0]    rd_b_reg;
    logic                 rd_a_vld_reg;
    logic                 rd_b_vld_reg;

    // Storage array, one write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Per-entry written flags; an unwritten entry reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Two registered read ports, held while no new word is captured.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg     <= mem_reg[rd_addr_a];
            rd_b_reg     <= mem_reg[rd_addr_b];
            rd_a_vld_reg <= valid_reg[rd_addr_a];
            rd_b_vld_reg <= valid_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_vld_reg ? rd_a_reg : '0;
    assign rd_data_b = rd_b_vld_reg ? rd_b_reg : '0;

endmodule

FILE: rtl/core/ssmalu_exec.sv
`timescale 1ns / 1ps

module ssmalu_exec (
    input  logic [7:0]                    action,
    input  logic [ssmalu_pkg::DATA_W-1:0] cur,
    input  logic [ssmalu_pkg::DATA_W-1:0] ind,
    input  logic [ssmalu_pkg::DATA_W-1:0] imm,
    output ssmalu_pkg::exec_res_t         res
);
    import ssmalu_pkg::*;

    logic is_cmp;
    logic take;

    // Decode the command and compute the new byte or the branch condition.
    always_comb begin
        res.flow  = FLOW_NONE;
        res.value = cur;
        res.write = 1'b0;
        is_cmp    = 1'b0;
        take      = 1'b0;
        unique case (action)
            ACT_STORE_IMM: begin res.write = 1'b1; res.value = imm; end
            ACT_ADD_IMM:   begin res.write = 1'b1; res.value = cur + imm; end
            ACT_SUB_IMM:   begin res.write = 1'b1; res.value = cur - imm; end
            ACT_STORE_IND: begin res.write = 1'b1; res.value = ind; end
            ACT_ADD_IND:   begin res.write = 1'b1; res.value = cur + ind; end
            ACT_SUB_IND:   begin res.write = 1'b1; res.value = cur - ind; end
            ACT_EQ_IMM:    begin is_cmp = 1'b1; take = (cur == imm); end
            ACT_NE_IMM:    begin is_cmp = 1'b1; take = (cur != imm); end
            ACT_GT_IMM:    begin is_cmp = 1'b1; take = (cur >  imm); end
            ACT_GE_IMM:    begin is_cmp = 1'b1; take = (cur >= imm); end
            ACT_LE_IMM:    begin is_cmp = 1'b1; take = (cur <= imm); end
            ACT_LT_IMM:    begin is_cmp = 1'b1; take = (cur <  imm); end
            ACT_EQ_IND:    begin is_cmp = 1'b1; take = (cur == ind); end
            ACT_NE_IND:    begin is_cmp = 1'b1; take = (cur != ind); end
            ACT_GT_IND:    begin is_cmp = 1'b1; take = (cur >  ind); end
            ACT_GE_IND:    begin is_cmp = 1'b1; take = (cur >= ind); end
            ACT_LE_IND:    begin is_cmp = 1'b1; take = (cur <= ind); end
            ACT_LT_IND:    begin is_cmp = 1'b1; take = (cur <  ind); end
            default:       begin is_cmp = 1'b0; end
        endcase
        if (is_cmp) begin
            res.flow = take ? FLOW_JUMP : FLOW_SKIP;
        end
    end

endmodule

FILE: rtl/core/script_scratch_memory_alu.sv
`timescale 1ns / 1ps
// Script scratch memory ALU: executes one store, add, subtract or compare command per word
// against a 256-byte scratch memory that reads as all zeros after reset, with no clearing
// pass. A new command word is accepted every cycle while the result side drains. The target
// and indirect bytes are read into registers at the edge that accepts the word. The compute
// works from those registers, and the write-back and the result's load into the output
// register happen at the edge where the execute stage advances. The previous command's write
// is forwarded so back-to-back commands on the same address see the updated byte. A result
// held by a stalled receiver, together with a word waiting in execute, blocks the input.
`include "script_scratch_memory_alu_macros.svh"

module script_scratch_memory_alu (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_action,
    input  logic [7:0] s_target_address,
    input  logic [7:0] s_operand,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_flow,
    output logic [7:0] m_target_value
);
    import ssmalu_pkg::*;

    logic              v1_reg;
    logic [7:0]        action_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] operand_reg;
    logic              fwd_vld_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [DATA_W-1:0] fwd_data_reg;
    logic              out_valid_reg;
    flow_t             flow_reg;
    logic [DATA_W-1:0] value_reg;

    logic              capture;
    logic              advance;
    logic              wr_en;
    logic [DATA_W-1:0] rd_a;
    logic [DATA_W-1:0] rd_b;
    logic [DATA_W-1:0] cur;
    logic [DATA_W-1:0] ind;
    exec_res_t         res;

    // Handshake: the execute stage moves on when the output register is free or drained.
    assign advance = v1_reg && (!out_valid_reg || m_ready);
    assign s_ready = !v1_reg || advance;
    assign capture = s_valid && s_ready;
    assign wr_en   = advance && res.write;

    ssmalu_mem u_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (capture),
        .rd_addr_a (s_target_address),
        .rd_addr_b (s_operand),
        .wr_en     (wr_en),
        .wr_addr   (addr_reg),
        .wr_data   (res.value),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    // Forward the write that landed at the same edge as this word's read.
    assign cur = (fwd_vld_reg && (fwd_addr_reg == addr_reg))    ? fwd_data_reg : rd_a;
    assign ind = (fwd_vld_reg && (fwd_addr_reg == operand_reg)) ? fwd_data_reg : rd_b;

    ssmalu_exec u_exec (
        .action (action_reg),
        .cur    (cur),
        .ind    (ind),
        .imm    (operand_reg),
        .res    (res)
    );

    // Execute stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_ready) begin
            v1_reg <= s_valid;
        end
    end

    // Execute stage payload and forwarding record.
    always_ff @(posedge aclk) begin
        if (capture) begin
            action_reg   <= s_action;
            addr_reg     <= s_target_address;
            operand_reg  <= s_operand;
            fwd_vld_reg  <= wr_en;
            fwd_addr_reg <= addr_reg;
            fwd_data_reg <= res.value;
        end
    end

    // Output register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (advance) begin
            flow_reg  <= res.flow;
            value_reg <= res.value;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_flow         = flow_reg;
    assign m_target_value = value_reg;

    // A result never carries the unused flow code.
    `SSMALU_ASSERT_NOW(a_flow_code, aclk, aresetn, m_valid, m_flow != 2'd3, "bad flow code")
    // A held word in execute must block the input while the output is stalled.
    `SSMALU_ASSERT_NOW(a_stall_blocks, aclk, aresetn, v1_reg && m_valid && !m_ready, !s_ready,
        "input accepted during full stall")
    // A written byte is the byte reported for that command.
    `SSMALU_ASSERT_NEXT(a_write_reported, aclk, aresetn, wr_en,
        m_valid && (m_target_value == $past(res.value)) && (m_flow == FLOW_NONE),
        "written byte differs from result")

endmodule
